// ===== src/drop_tail_link_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Drop-tail link queue assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef DROP_TAIL_LINK_QUEUE_DEFINES_SVH
`define DROP_TAIL_LINK_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define DTLQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DTLQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dtlq_pkg.sv =====
// ----------------------------------------------------------------------------
// Drop-tail link queue package
// Widths, payload structs, control structs, the sequencer state type and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtlq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int LIMIT_W     = 7;
    localparam int CMP_W       = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;

    localparam int TIME_W  = 48;
    localparam int BYTES_W = 16;
    localparam int BTIME_W = 16;
    localparam int PROD_W  = BYTES_W + BTIME_W;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 56;
    localparam int OCC_W   = 7;
    localparam int SLOT_W  = TIME_W + BYTES_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TIME   = 2'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
    localparam logic [BTIME_W-1:0] BTIME_RESET = 16'd1333;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_FLUSH   = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [TIME_W-1:0]  arrival_time;
        logic [BYTES_W-1:0] packet_bytes;
    } in_item_t;

    typedef struct packed {
        logic               dropped;
        logic [OCC_W-1:0]   occupancy;
        logic [CNT_W-1:0]   arrivals_total;
        logic [CNT_W-1:0]   delivered_total;
        logic [CNT_W-1:0]   lost_total;
        logic [SUM_W-1:0]   delay_sum;
        logic [TIME_W-1:0]  server_free_time;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]  arrival;
        logic [BYTES_W-1:0] bytes;
    } slot_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_SERVE,
        ST_ENQ,
        ST_FINISH
    } state_t;

    // Sequencer to datapath.
    typedef struct packed {
        logic busy;
        logic accept;
        logic ram_read;
        logic serve_latch;
        logic serve_commit;
        logic enqueue;
        logic load_out;
    } ctrl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic in_valid;
        logic fill_zero;
        logic flush;
        logic phase;
        logic can_serve;
        logic out_free;
    } status_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1))
            res = '0;
        else
            res = ptr + PTR_W'(1);
        return res;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] res;
        if (v == '1)
            res = v;
        else
            res = v + CNT_W'(1);
        return res;
    endfunction

endpackage

// ===== src/drop_tail_link_queue.sv =====
// ----------------------------------------------------------------------------
// Drop-tail link queue
// Trace-driven single-server queue with a finite buffer and tail drop.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one transaction
//   per trace item: a packet arrival with its timestamp and size, or a flush
//   that serves every buffered packet. Each item yields exactly one result
//   transaction on the output channel (out_valid, out_stall, out_data) with
//   the drop flag, occupancy, running counters, delay sum and server time.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   sets the buffer limit (index 0) and the per-byte time (index 1); it is
//   always ready and should only be written while the block is idle.
//   Items are handled one at a time. Each packet served passes through a
//   slot memory read, a start-time evaluation and a commit, as the slot
//   memory read and the multiply are both registered. in_stall is high
//   from acceptance until the result is placed in the output register.
//   A waiting result does not hold up the next item: only when a finished
//   result finds the output register still stalled does the block wait.
//   Reset empties the queue, clears every counter and the server time, and
//   restores the limit to 64 and the byte time to 1333. Slot contents are
//   not cleared, as only written slots are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drop_tail_link_queue
    import dtlq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [LIMIT_W-1:0] limit_reg;
    logic [BTIME_W-1:0] btime_reg;
    ctrl_t              ctrl;
    status_t            status;

    // Configuration writes are always accepted; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            btime_reg <= BTIME_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_QUEUE_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_BYTE_TIME:   btime_reg <= cfg_data[BTIME_W-1:0];
                default:         ;
            endcase
        end
    end

    // The sequencer decides the step; the datapath holds all queue state.
    dtlq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    dtlq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .in_valid    (in_valid),
        .in_data     (in_data),
        .queue_limit (limit_reg),
        .byte_time   (btime_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    // A new item is taken only while the sequencer is idle.
    assign in_stall = ctrl.busy;

endmodule

// ===== src/dtlq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered and appears in the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtlq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dtlq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Drop-tail link queue sequencer
// Walks one item through read, evaluate, serve, enqueue and finish steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtlq_ctrl
    import dtlq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                if (!status.fill_zero)
                    state_next = ST_EVAL;
                else if (!status.flush && !status.phase)
                    state_next = ST_ENQ;
                else
                    state_next = ST_FINISH;
            end
            ST_EVAL:
            begin
                if (status.can_serve)
                    state_next = ST_SERVE;
                else if (!status.flush && !status.phase)
                    state_next = ST_ENQ;
                else
                    state_next = ST_FINISH;
            end
            ST_SERVE:
            begin
                state_next = ST_READ;
            end
            ST_ENQ:
            begin
                state_next = ST_READ;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        ctrl.busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:   ctrl.accept       = status.in_valid;
            ST_READ:   ctrl.ram_read     = !status.fill_zero;
            ST_EVAL:   ctrl.serve_latch  = status.can_serve;
            ST_SERVE:  ctrl.serve_commit = 1'b1;
            ST_ENQ:    ctrl.enqueue      = 1'b1;
            ST_FINISH: ctrl.load_out     = status.out_free;
            default:   ctrl.busy         = 1'b1;
        endcase
    end

endmodule

// ===== src/dtlq_datapath.sv =====
// ----------------------------------------------------------------------------
// Drop-tail link queue datapath
// Slot memory, ring pointers, server time, counters and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtlq_datapath
    import dtlq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_t              ctrl,
    output status_t            status,
    input  logic               in_valid,
    input  in_item_t           in_data,
    input  logic [LIMIT_W-1:0] queue_limit,
    input  logic [BTIME_W-1:0] byte_time,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data
);

    in_item_t           item_reg;
    logic               phase_reg;
    logic               dropped_reg;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   tail_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [TIME_W-1:0]  free_reg;
    logic [CNT_W-1:0]   arrive_reg;
    logic [CNT_W-1:0]   serve_reg;
    logic [CNT_W-1:0]   drop_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [TIME_W-1:0]  start_reg;
    logic [TIME_W-1:0]  arr_reg;
    logic [PROD_W-1:0]  prod_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;

    slot_t              head_slot;
    logic [SLOT_W-1:0]  ram_rdata;
    logic [TIME_W-1:0]  start_c;
    logic [PROD_W-1:0]  prod_c;
    logic [CMP_W-1:0]   limit_c;
    logic               can_enq;
    logic               ram_we;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_next;
    logic [TIME_W:0]    fin_wide;
    logic [TIME_W-1:0]  free_next;

    assign ram_we = ctrl.enqueue && can_enq;

    dtlq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata ({item_reg.arrival_time, item_reg.packet_bytes}),
        .re    (ctrl.ram_read),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign head_slot = slot_t'(ram_rdata);

    always_comb
    begin
        start_c = (free_reg > head_slot.arrival) ? free_reg : head_slot.arrival;
        prod_c  = PROD_W'(head_slot.bytes) * PROD_W'(byte_time);

        if (CMP_W'(queue_limit) > CMP_W'(QUEUE_DEPTH))
            limit_c = CMP_W'(QUEUE_DEPTH);
        else
            limit_c = CMP_W'(queue_limit);
        can_enq = CMP_W'(fill_reg) < limit_c;

        sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(start_reg - arr_reg);
        sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        fin_wide = {1'b0, start_reg} + (TIME_W + 1)'(prod_reg);
        free_next = fin_wide[TIME_W] ? '1 : fin_wide[TIME_W-1:0];
    end

    always_comb
    begin
        status.in_valid  = in_valid;
        status.fill_zero = (fill_reg == '0);
        status.flush     = (item_reg.operation == OP_FLUSH);
        status.phase     = phase_reg;
        status.can_serve = (item_reg.operation == OP_FLUSH)
                           || (start_c <= item_reg.arrival_time);
        status.out_free  = !out_valid_reg || !out_stall;
    end

    // Payload-only registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            item_reg <= in_data;
        end
        if (ctrl.serve_latch)
        begin
            start_reg <= start_c;
            arr_reg   <= head_slot.arrival;
            prod_reg  <= prod_c;
        end
        if (ctrl.load_out)
        begin
            out_reg.dropped          <= dropped_reg;
            out_reg.occupancy        <= OCC_W'(fill_reg);
            out_reg.arrivals_total   <= arrive_reg;
            out_reg.delivered_total  <= serve_reg;
            out_reg.lost_total       <= drop_reg;
            out_reg.delay_sum        <= sum_reg;
            out_reg.server_free_time <= free_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            free_reg      <= '0;
            arrive_reg    <= '0;
            serve_reg     <= '0;
            drop_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.accept)
            begin
                phase_reg   <= 1'b0;
                dropped_reg <= 1'b0;
                if (in_data.operation == OP_ARRIVAL)
                    arrive_reg <= sat_inc(arrive_reg);
            end
            if (ctrl.serve_commit)
            begin
                sum_reg   <= sum_next;
                free_reg  <= free_next;
                head_reg  <= ptr_inc(head_reg);
                fill_reg  <= fill_reg - FILL_W'(1);
                serve_reg <= sat_inc(serve_reg);
            end
            if (ctrl.enqueue)
            begin
                phase_reg <= 1'b1;
                if (can_enq)
                begin
                    tail_reg <= ptr_inc(tail_reg);
                    fill_reg <= fill_reg + FILL_W'(1);
                end
                else
                begin
                    dropped_reg <= 1'b1;
                    drop_reg    <= sat_inc(drop_reg);
                end
            end
            if (ctrl.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== src/dtlq_checker.sv =====
// ----------------------------------------------------------------------------
// Drop-tail link queue checker
// Port-level assertions on the queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "drop_tail_link_queue_defines.svh"

module dtlq_checker
    import dtlq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    logic occ_ok;
    logic served_ok;

    assign occ_ok    = int'(out_data.occupancy) <= QUEUE_DEPTH;
    assign served_ok = out_data.delivered_total <= out_data.arrivals_total;

    // A stalled result stays on offer.
    `DTLQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result withdrawn")

    // Items are handled one at a time, so acceptance closes the input.
    `DTLQ_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "input open after accept")

    // The buffer never holds more packets than it has slots.
    `DTLQ_ASSERT_NOW(a_occ_bound, out_valid, occ_ok, "occupancy beyond depth")

    // A packet is never served that did not arrive.
    `DTLQ_ASSERT_NOW(a_served_le_arrived, out_valid, served_ok, "more served than arrived")

endmodule

bind drop_tail_link_queue dtlq_checker u_dtlq_checker (.*);
